@@ rtl/rtsc_pkg.sv @@
// Package: shared codes, widths and constant tables of the tune/scan controller.
`timescale 1ns / 1ps
`default_nettype none

package rtsc_pkg;

  localparam int FREQ_W   = 27;
  localparam int MODE_W   = 3;
  localparam int BW_W     = 14;
  localparam int STEP_W   = 17;
  localparam int PRESET_W = 5;
  localparam int VOL_W    = 8;
  localparam int SIG_W    = 10;
  localparam int TICK_W   = 16;
  localparam int KEY_N    = 7;

  localparam int PRESET_COUNT_DEF = 18;
  localparam int ROM_ENTRIES      = 18;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 27;

  typedef logic [FREQ_W-1:0]   freq_t;
  typedef logic [MODE_W-1:0]   mode_t;
  typedef logic [BW_W-1:0]     bw_t;
  typedef logic [STEP_W-1:0]   step_t;
  typedef logic [PRESET_W-1:0] preset_t;
  typedef logic [VOL_W-1:0]    vol_t;
  typedef logic [SIG_W-1:0]    sig_t;
  typedef logic [TICK_W-1:0]   tick_t;
  typedef logic [KEY_N-1:0]    keys_t;

  // Demodulation mode codes
  localparam mode_t MODE_AM       = 3'd0;
  localparam mode_t MODE_UPPER_SB = 3'd1;
  localparam mode_t MODE_LOWER_SB = 3'd2;
  localparam mode_t MODE_CW       = 3'd3;
  localparam mode_t MODE_FM       = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SQUELCH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DWELL    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAUSE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FINE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HF_CEIL  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_CEIL = 3'd5;

  // Key bit positions in the edge-detect vector
  localparam int KEY_UP       = 0;
  localparam int KEY_DOWN     = 1;
  localparam int KEY_SCAN     = 2;
  localparam int KEY_MODE     = 3;
  localparam int KEY_PRESET   = 4;
  localparam int KEY_VOL_DOWN = 5;
  localparam int KEY_VOL_UP   = 6;

  localparam vol_t VOL_STEP = 8'd10;
  localparam vol_t VOL_MAX  = 8'd255;
  localparam vol_t VOL_UP_LIMIT = 8'd245;

  // Out-of-table modes behave as AM
  function automatic mode_t safe_mode(input mode_t m);
    return (m > MODE_FM) ? MODE_AM : m;
  endfunction

  function automatic bw_t bw_of(input mode_t m);
    bw_t r;
    unique case (safe_mode(m)) inside
      MODE_UPPER_SB, MODE_LOWER_SB: r = 14'd2800;
      MODE_CW:  r = 14'd500;
      MODE_FM:  r = 14'd15000;
      default:  r = 14'd6000;
    endcase
    return r;
  endfunction

  function automatic step_t step_of(input mode_t m, input logic fine);
    step_t r;
    unique case (safe_mode(m)) inside
      MODE_UPPER_SB, MODE_LOWER_SB: r = fine ? 17'd100 : 17'd1000;
      MODE_CW:  r = fine ? 17'd10    : 17'd100;
      MODE_FM:  r = fine ? 17'd10000 : 17'd100000;
      default:  r = fine ? 17'd1000  : 17'd5000;
    endcase
    return r;
  endfunction

  // Preset ROM; numbers without an entry read as entry 0
  function automatic freq_t preset_hz(input preset_t p);
    freq_t r;
    unique case (p)
      5'd1:    r = 27'd10000000;
      5'd2:    r = 27'd15000000;
      5'd3:    r = 27'd3550000;
      5'd4:    r = 27'd3750000;
      5'd5:    r = 27'd7030000;
      5'd6:    r = 27'd7200000;
      5'd7:    r = 27'd7290000;
      5'd8:    r = 27'd14060000;
      5'd9:    r = 27'd14200000;
      5'd10:   r = 27'd14300000;
      5'd11:   r = 27'd21060000;
      5'd12:   r = 27'd21200000;
      5'd13:   r = 27'd28400000;
      5'd14:   r = 27'd9420000;
      5'd15:   r = 27'd6195000;
      5'd16:   r = 27'd11735000;
      5'd17:   r = 27'd4840000;
      default: r = 27'd5000000;
    endcase
    return r;
  endfunction

  function automatic mode_t preset_mode(input preset_t p);
    mode_t r;
    unique case (p) inside
      5'd3, 5'd5, 5'd8, 5'd11:         r = MODE_CW;
      5'd4, 5'd6, 5'd7:                r = MODE_LOWER_SB;
      5'd9, 5'd10, 5'd12, 5'd13:       r = MODE_UPPER_SB;
      default:                         r = MODE_AM;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/rtsc_if.sv @@
// Interfaces: input item, result item and configuration write channels.
`timescale 1ns / 1ps
`default_nettype none

interface rtsc_in_if
  import rtsc_pkg::*;
();
  logic valid;
  logic ready;
  logic key_up;
  logic key_down;
  logic key_scan;
  logic key_mode;
  logic key_preset;
  logic key_vol_down;
  logic key_vol_up;
  logic link_up;
  sig_t signal_level;

  modport source (
    output valid, key_up, key_down, key_scan, key_mode, key_preset,
           key_vol_down, key_vol_up, link_up, signal_level,
    input  ready
  );
  modport sink (
    input  valid, key_up, key_down, key_scan, key_mode, key_preset,
           key_vol_down, key_vol_up, link_up, signal_level,
    output ready
  );
endinterface

interface rtsc_out_if
  import rtsc_pkg::*;
();
  logic    valid;
  logic    ready;
  logic    tune_valid;
  freq_t   tune_freq_hz;
  mode_t   tune_mode;
  bw_t     tune_bandwidth_hz;
  logic    scan_active;
  logic    scan_holding;
  preset_t preset_number;
  vol_t    volume_level;
  logic    volume_changed;

  modport source (
    output valid, tune_valid, tune_freq_hz, tune_mode, tune_bandwidth_hz,
           scan_active, scan_holding, preset_number, volume_level, volume_changed,
    input  ready
  );
  modport sink (
    input  valid, tune_valid, tune_freq_hz, tune_mode, tune_bandwidth_hz,
           scan_active, scan_holding, preset_number, volume_level, volume_changed,
    output ready
  );
endinterface

interface rtsc_cfg_if
  import rtsc_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/receiver_tune_scan_controller_unit.sv @@
// Top level: receiver tune and scan controller.
`timescale 1ns / 1ps
`default_nettype none

// Every accepted frame-tick item produces exactly one result item, in the next
// cycle, in an output register. The whole tick (key edge detect, tuning steps
// with ceiling clamps, mode and preset changes, volume, scanner dwell/hold
// counters and the tune-command flag) is evaluated in one pass of
// combinational logic from the incoming item and the state registers, so the
// block takes one item per clock: in.ready is high whenever the output
// register is empty or its result is being taken in the same cycle. The rate
// is set by that combinational state update loop. Configuration writes are
// always ready and should only be issued while no result is outstanding.
// Reset is synchronous; there is no clearing pass.
module receiver_tune_scan_controller_unit
  import rtsc_pkg::*;
#(
  parameter int PRESET_COUNT = PRESET_COUNT_DEF
) (
  input  wire          clk,
  input  wire          rst,
  rtsc_in_if.sink      in_ch,
  rtsc_out_if.source   out_ch,
  rtsc_cfg_if.sink     cfg
);

  localparam logic [PRESET_W:0] PCNT = (PRESET_W+1)'(PRESET_COUNT);

  // Configuration registers
  sig_t  squelch_level;
  tick_t dwell_ticks;
  tick_t pause_ticks;
  logic  fine_step_select;
  freq_t hf_ceiling_hz;
  freq_t top_ceiling_hz;

  // Controller state
  freq_t   freq;
  mode_t   mode;
  bw_t     bandwidth;
  preset_t preset;
  logic    scanning;
  tick_t   dwell_count;
  tick_t   hold_count;
  logic    pending;
  vol_t    volume;
  keys_t   prev_keys;

  freq_t   freq_next;
  mode_t   mode_next;
  bw_t     bandwidth_next;
  preset_t preset_next;
  logic    scanning_next;
  tick_t   dwell_count_next;
  tick_t   hold_count_next;
  logic    pending_next;
  vol_t    volume_next;
  logic    tune_valid_next;
  logic    vol_changed_next;
  keys_t   keys;

  logic in_fire;

  assign cfg.ready    = 1'b1;
  assign in_ch.ready  = !out_ch.valid || out_ch.ready;
  assign in_fire      = in_ch.valid && in_ch.ready;

  assign keys = {in_ch.key_vol_up, in_ch.key_vol_down, in_ch.key_preset,
                 in_ch.key_mode, in_ch.key_scan, in_ch.key_down, in_ch.key_up};

  // Wrap to zero past the configured preset count
  function automatic preset_t preset_advance(input preset_t p);
    preset_t inc;
    inc = p + 1'b1;
    return ({1'b0, inc} >= PCNT) ? '0 : inc;
  endfunction

  always_comb begin
    keys_t          pressed;
    step_t          step;
    logic [FREQ_W:0] sum;
    logic           link;

    pressed = keys & ~prev_keys;
    link    = in_ch.link_up;
    step    = step_of(mode, fine_step_select);

    freq_next        = freq;
    mode_next        = mode;
    bandwidth_next   = bandwidth;
    preset_next      = preset;
    scanning_next    = scanning;
    dwell_count_next = dwell_count;
    hold_count_next  = hold_count;
    pending_next     = pending;
    volume_next      = volume;
    vol_changed_next = 1'b0;
    sum              = '0;

    if (link) begin
      if (pressed[KEY_UP]) begin
        sum = {1'b0, freq_next} + {{(FREQ_W+1-STEP_W){1'b0}}, step};
        if (sum > {1'b0, hf_ceiling_hz} && mode_next != MODE_FM) begin
          sum = {1'b0, hf_ceiling_hz};
        end
        if (sum > {1'b0, top_ceiling_hz}) begin
          sum = {1'b0, top_ceiling_hz};
        end
        freq_next     = sum[FREQ_W-1:0];
        pending_next  = 1'b1;
        scanning_next = 1'b0;
      end
      if (pressed[KEY_DOWN]) begin
        // below one step the frequency lands on exactly one step
        if (freq_next > FREQ_W'(step)) begin
          freq_next = freq_next - FREQ_W'(step);
        end else begin
          freq_next = FREQ_W'(step);
        end
        pending_next  = 1'b1;
        scanning_next = 1'b0;
      end
      if (pressed[KEY_SCAN]) begin
        scanning_next    = !scanning_next;
        dwell_count_next = '0;
        hold_count_next  = '0;
      end
      if (pressed[KEY_MODE]) begin
        mode_next      = (safe_mode(mode_next) == MODE_FM) ? MODE_AM
                                                           : safe_mode(mode_next) + 1'b1;
        bandwidth_next = bw_of(mode_next);
        pending_next   = 1'b1;
      end
      if (pressed[KEY_PRESET]) begin
        preset_next    = preset_advance(preset_next);
        freq_next      = preset_hz(preset_next);
        mode_next      = preset_mode(preset_next);
        bandwidth_next = bw_of(mode_next);
        pending_next   = 1'b1;
      end
      if (pressed[KEY_VOL_DOWN]) begin
        volume_next      = (volume_next >= VOL_STEP) ? volume_next - VOL_STEP : '0;
        vol_changed_next = 1'b1;
      end
      if (pressed[KEY_VOL_UP]) begin
        volume_next      = (volume_next <= VOL_UP_LIMIT) ? volume_next + VOL_STEP : VOL_MAX;
        vol_changed_next = 1'b1;
      end
    end

    // Scanner: hold on a signal, otherwise dwell then advance
    if (scanning_next) begin
      if (hold_count_next != '0) begin
        hold_count_next = hold_count_next - 1'b1;
        if (in_ch.signal_level < squelch_level) begin
          hold_count_next = '0;
        end
      end else begin
        dwell_count_next = dwell_count_next + 1'b1;
        if (dwell_count_next < dwell_ticks) begin
          if (in_ch.signal_level >= squelch_level) begin
            hold_count_next  = pause_ticks;
            dwell_count_next = '0;
          end
        end else begin
          dwell_count_next = '0;
          preset_next      = preset_advance(preset_next);
          freq_next        = preset_hz(preset_next);
          mode_next        = preset_mode(preset_next);
          bandwidth_next   = bw_of(mode_next);
          pending_next     = 1'b1;
        end
      end
    end

    tune_valid_next = pending_next && link;
    if (tune_valid_next) begin
      pending_next = 1'b0;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      squelch_level    <= 10'd300;
      dwell_ticks      <= 16'd180;
      pause_ticks      <= 16'd300;
      fine_step_select <= 1'b0;
      hf_ceiling_hz    <= 27'd30000000;
      top_ceiling_hz   <= 27'd108000000;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_SQUELCH:  squelch_level    <= cfg.data[SIG_W-1:0];
        REG_DWELL:    dwell_ticks      <= cfg.data[TICK_W-1:0];
        REG_PAUSE:    pause_ticks      <= cfg.data[TICK_W-1:0];
        REG_FINE:     fine_step_select <= cfg.data[0];
        REG_HF_CEIL:  hf_ceiling_hz    <= cfg.data[FREQ_W-1:0];
        REG_TOP_CEIL: top_ceiling_hz   <= cfg.data[FREQ_W-1:0];
        default: ;
      endcase
    end
  end

  // State update, one tick per accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      freq        <= 27'd10000000;
      mode        <= MODE_AM;
      bandwidth   <= 14'd6000;
      preset      <= 5'd1;
      scanning    <= 1'b0;
      dwell_count <= '0;
      hold_count  <= '0;
      pending     <= 1'b1;
      volume      <= VOL_MAX;
      prev_keys   <= '0;
    end else if (in_fire) begin
      freq        <= freq_next;
      mode        <= mode_next;
      bandwidth   <= bandwidth_next;
      preset      <= preset_next;
      scanning    <= scanning_next;
      dwell_count <= dwell_count_next;
      hold_count  <= hold_count_next;
      pending     <= pending_next;
      volume      <= volume_next;
      prev_keys   <= keys;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (in_fire) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_ch.tune_valid        <= tune_valid_next;
      out_ch.tune_freq_hz      <= freq_next;
      out_ch.tune_mode         <= mode_next;
      out_ch.tune_bandwidth_hz <= bandwidth_next;
      out_ch.scan_active       <= scanning_next;
      out_ch.scan_holding      <= scanning_next && (hold_count_next != '0);
      out_ch.preset_number     <= preset_next;
      out_ch.volume_level      <= volume_next;
      out_ch.volume_changed    <= vol_changed_next;
    end
  end

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// Testbench: tune/scan controller checked item by item against an in-bench radio predictor.
`timescale 1ns / 1ps

module tb_top;
  import rtsc_pkg::*;

  // Spare register index: the block must ignore writes to it.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  localparam int unsigned FREQ_MASK = (1 << FREQ_W) - 1;
  localparam int unsigned N_PRESETS = PRESET_COUNT_DEF;
  localparam int DIR_N = 25;

  // Key sets, built from the package bit positions
  localparam keys_t K_NONE   = '0;
  localparam keys_t K_ALL    = '1;
  localparam keys_t K_UP     = keys_t'(1) << KEY_UP;
  localparam keys_t K_DOWN   = keys_t'(1) << KEY_DOWN;
  localparam keys_t K_SCAN   = keys_t'(1) << KEY_SCAN;
  localparam keys_t K_MODE   = keys_t'(1) << KEY_MODE;
  localparam keys_t K_PRESET = keys_t'(1) << KEY_PRESET;
  localparam keys_t K_VDN    = keys_t'(1) << KEY_VOL_DOWN;
  localparam keys_t K_VUP    = keys_t'(1) << KEY_VOL_UP;

  // One frame tick as driven into the block
  typedef struct packed {
    keys_t keys;
    logic  link;
    sig_t  level;
  } frame_t;

  // One result item, field for field
  typedef struct packed {
    logic    tune_valid;
    freq_t   freq;
    mode_t   mode;
    bw_t     bw;
    logic    scan;
    logic    hold;
    preset_t preset;
    vol_t    vol;
    logic    vol_chg;
  } status_t;

  // Directed row: stimulus, and a typed expectation where `typed` is set
  typedef struct packed {
    frame_t  f;
    logic    typed;
    status_t s;
  } dir_row_t;

  logic clk;
  logic rst;

  rtsc_in_if  in_ch ();
  rtsc_out_if out_ch ();
  rtsc_cfg_if cfg_ch ();

  receiver_tune_scan_controller_unit i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg_ch)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: shadow configuration and radio state
  // ---------------------------------------------------------------------------
  int unsigned sq_lvl, dwell_lim, pause_lim, hf_ceil, top_ceil;
  logic        fine_sel;

  int unsigned r_freq, r_bw, r_preset, r_dwell, r_hold, r_vol;
  mode_t       r_mode;
  logic        r_scan, r_pend;
  keys_t       r_prev;

  status_t  status_q [$];   // expected result items, oldest first
  dir_row_t dir_tab [DIR_N];
  int       fail_count;
  int       src_idle_pct;   // percent of cycles the item source holds off
  int       snk_idle_pct;   // percent of cycles the result sink stalls

  // ---------------------------------------------------------------------------
  // Per-mode tables and the preset ROM, written out here on their own
  // ---------------------------------------------------------------------------
  function automatic int unsigned step_hz(input mode_t m);
    case (m) inside
      MODE_UPPER_SB, MODE_LOWER_SB: return fine_sel ? 100 : 1000;
      MODE_CW:            return fine_sel ? 10 : 100;
      MODE_FM:            return fine_sel ? 10000 : 100000;
      default:            return fine_sel ? 1000 : 5000;   // AM and anything off-table
    endcase
  endfunction

  function automatic int unsigned bw_hz(input mode_t m);
    case (m) inside
      MODE_UPPER_SB, MODE_LOWER_SB: return 2800;
      MODE_CW:            return 500;
      MODE_FM:            return 15000;
      default:            return 6000;
    endcase
  endfunction

  function automatic int unsigned rom_hz(input int unsigned idx);
    case (idx)
      1:  return 10000000;
      2:  return 15000000;
      3:  return 3550000;
      4:  return 3750000;
      5:  return 7030000;
      6:  return 7200000;
      7:  return 7290000;
      8:  return 14060000;
      9:  return 14200000;
      10: return 14300000;
      11: return 21060000;
      12: return 21200000;
      13: return 28400000;
      14: return 9420000;
      15: return 6195000;
      16: return 11735000;
      17: return 4840000;
      default: return 5000000;
    endcase
  endfunction

  function automatic mode_t rom_mode(input int unsigned idx);
    case (idx) inside
      3, 5, 8, 11:   return MODE_CW;
      4, 6, 7:       return MODE_LOWER_SB;
      9, 10, 12, 13: return MODE_UPPER_SB;
      default:       return MODE_AM;
    endcase
  endfunction

  // Next preset number, wrapping at the preset count; loads freq/mode from ROM
  task automatic step_preset();
    int unsigned idx;
    r_preset = (r_preset + 1) & 32'h1F;
    if (r_preset >= N_PRESETS) r_preset = 0;
    idx = (r_preset < ROM_ENTRIES) ? r_preset : 0;
    r_freq = rom_hz(idx);
    r_mode = rom_mode(idx);
    r_bw   = bw_hz(r_mode);
    r_pend = 1'b1;
  endtask

  // Scanner: hold while the signal stays up, else count dwell and advance
  task automatic run_scan(input sig_t lvl);
    if (!r_scan) return;
    if (r_hold > 0) begin
      r_hold--;
      if (lvl < sq_lvl) r_hold = 0;   // signal dropped: resume early
      return;
    end
    r_dwell = (r_dwell + 1) & 32'hFFFF;
    if (r_dwell < dwell_lim) begin
      if (lvl >= sq_lvl) begin
        r_hold  = pause_lim;
        r_dwell = 0;
      end
      return;
    end
    r_dwell = 0;
    step_preset();
  endtask

  // One frame tick: key edges and actions, scanner, tune emission
  task automatic advance_radio(input frame_t f, output status_t s);
    keys_t       edges;
    int unsigned stp;
    logic        vchg;
    logic        tv;
    edges  = f.keys & ~r_prev;
    r_prev = f.keys;
    vchg   = 1'b0;
    tv     = 1'b0;
    // With the link down edges are tracked but no key acts.
    if (f.link) begin
      if (edges[KEY_UP]) begin
        r_freq = r_freq + step_hz(r_mode);
        if (r_freq > hf_ceil && r_mode != MODE_FM) r_freq = hf_ceil;
        if (r_freq > top_ceil) r_freq = top_ceil;
        r_freq = r_freq & FREQ_MASK;
        r_pend = 1'b1;
        r_scan = 1'b0;
      end
      if (edges[KEY_DOWN]) begin
        stp    = step_hz(r_mode);
        r_freq = (r_freq > stp) ? r_freq - stp : stp;   // floor at one step
        r_pend = 1'b1;
        r_scan = 1'b0;
      end
      if (edges[KEY_SCAN]) begin
        r_scan  = !r_scan;
        r_dwell = 0;
        r_hold  = 0;
      end
      if (edges[KEY_MODE]) begin
        r_mode = (r_mode == MODE_FM) ? MODE_AM :
                 (r_mode > MODE_FM)  ? MODE_UPPER_SB : mode_t'(r_mode + 3'd1);
        r_bw   = bw_hz(r_mode);
        r_pend = 1'b1;
      end
      if (edges[KEY_PRESET]) step_preset();
      if (edges[KEY_VOL_DOWN]) begin
        r_vol = (r_vol >= VOL_STEP) ? r_vol - VOL_STEP : 0;
        vchg  = 1'b1;
      end
      if (edges[KEY_VOL_UP]) begin
        r_vol = (r_vol <= VOL_UP_LIMIT) ? r_vol + VOL_STEP : VOL_MAX;
        vchg  = 1'b1;
      end
    end

    run_scan(f.level);

    if (r_pend && f.link) begin
      r_pend = 1'b0;
      tv     = 1'b1;
    end

    s.tune_valid = tv;
    s.freq       = freq_t'(r_freq & FREQ_MASK);
    s.mode       = r_mode;
    s.bw         = bw_t'(r_bw);
    s.scan       = r_scan;
    s.hold       = r_scan && (r_hold > 0);
    s.preset     = preset_t'(r_preset);
    s.vol        = vol_t'(r_vol);
    s.vol_chg    = vchg;
  endtask

  function automatic frame_t frame(input keys_t k, input logic lk, input sig_t lvl);
    frame_t f;
    f.keys  = k;
    f.link  = lk;
    f.level = lvl;
    return f;
  endfunction

  // Signal levels: rails, near the squelch threshold, or anywhere
  function automatic sig_t pick_level();
    int v;
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      2: begin
        v = int'(sq_lvl) + int'($urandom_range(4)) - 2;
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        return sig_t'(v);
      end
      default: return sig_t'($urandom_range(1023));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers. Inputs change on the falling edge; handshakes are seen on rising.
  // Tasks below are entered and left at a falling edge.
  // ---------------------------------------------------------------------------

  // Send one item; record the typed row or the predicted one once accepted.
  // valid is left high on return so back-to-back items stay back to back.
  task automatic send_frame(input frame_t f, input logic typed, input status_t want);
    status_t pred;
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.key_up       <= f.keys[KEY_UP];
    in_ch.key_down     <= f.keys[KEY_DOWN];
    in_ch.key_scan     <= f.keys[KEY_SCAN];
    in_ch.key_mode     <= f.keys[KEY_MODE];
    in_ch.key_preset   <= f.keys[KEY_PRESET];
    in_ch.key_vol_down <= f.keys[KEY_VOL_DOWN];
    in_ch.key_vol_up   <= f.keys[KEY_VOL_UP];
    in_ch.link_up      <= f.link;
    in_ch.signal_level <= f.level;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    advance_radio(f, pred);
    status_q.push_back(typed ? want : pred);
    @(negedge clk);
  endtask

  // Stop sending and wait until every expected result has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (status_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // One register write; cfg valid stays high for a following write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_SQUELCH:  sq_lvl    = val & ((1 << SIG_W) - 1);
      REG_DWELL:    dwell_lim = val & ((1 << TICK_W) - 1);
      REG_PAUSE:    pause_lim = val & ((1 << TICK_W) - 1);
      REG_FINE:     fine_sel  = val[0];
      REG_HF_CEIL:  hf_ceil   = val & FREQ_MASK;
      REG_TOP_CEIL: top_ceil  = val & FREQ_MASK;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // New setting for a phase; only issued once the block has gone idle
  task automatic retune_config(input int unsigned sq, input int unsigned dw,
                               input int unsigned pa, input int unsigned fi,
                               input int unsigned hf, input int unsigned top);
    drain();
    write_reg(REG_SQUELCH, sq);
    write_reg(REG_DWELL, dw);
    write_reg(REG_PAUSE, pa);
    write_reg(REG_FINE, fi);
    write_reg(REG_HF_CEIL, hf);
    write_reg(REG_TOP_CEIL, top);
    cfg_ch.valid <= 1'b0;
  endtask

  // Random traffic: mostly clean press/release gestures with quiet ticks
  // after them so the scanner runs, some raw noise, and the odd volume sweep
  // that drives the volume into either rail.
  task automatic play_random(input int quota);
    int    n;
    int    pick;
    int    run;
    keys_t k;
    logic  lk;
    n = 0;
    while (n < quota) begin
      pick = $urandom_range(99);
      if (pick < 2) begin
        k = $urandom_range(1) ? K_VDN : K_VUP;
        repeat (28) begin
          send_frame(frame(k, 1'b1, pick_level()), 1'b0, '0);
          send_frame(frame(K_NONE, 1'b1, pick_level()), 1'b0, '0);
        end
        n += 56;
      end else if (pick < 20) begin
        send_frame(frame(keys_t'($urandom_range(127)), 1'($urandom_range(1)),
                         sig_t'($urandom_range(1023))), 1'b0, '0);
        n++;
      end else begin
        k = keys_t'(1) << $urandom_range(KEY_N - 1);
        if ($urandom_range(5) == 0) k |= keys_t'(1) << $urandom_range(KEY_N - 1);
        lk  = ($urandom_range(9) != 0);
        run = $urandom_range(1, 2);
        repeat (run) send_frame(frame(k, lk, pick_level()), 1'b0, '0);
        n += run;
        run = $urandom_range(1, 8);
        repeat (run) send_frame(frame(K_NONE, 1'b1, pick_level()), 1'b0, '0);
        n += run;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic check_status(input status_t got);
    status_t e;
    if (status_q.size() == 0) begin
      $error("result item with no expectation waiting");
      fail_count++;
      return;
    end
    e = status_q.pop_front();
    if (got.tune_valid !== e.tune_valid) begin
      $error("tune_valid: expected %0d, got %0d", e.tune_valid, got.tune_valid);
      fail_count++;
    end
    if (got.freq !== e.freq) begin
      $error("tune_freq_hz: expected %0d, got %0d", e.freq, got.freq);
      fail_count++;
    end
    if (got.mode !== e.mode) begin
      $error("tune_mode: expected %0d, got %0d", e.mode, got.mode);
      fail_count++;
    end
    if (got.bw !== e.bw) begin
      $error("tune_bandwidth_hz: expected %0d, got %0d", e.bw, got.bw);
      fail_count++;
    end
    if (got.scan !== e.scan) begin
      $error("scan_active: expected %0d, got %0d", e.scan, got.scan);
      fail_count++;
    end
    if (got.hold !== e.hold) begin
      $error("scan_holding: expected %0d, got %0d", e.hold, got.hold);
      fail_count++;
    end
    if (got.preset !== e.preset) begin
      $error("preset_number: expected %0d, got %0d", e.preset, got.preset);
      fail_count++;
    end
    if (got.vol !== e.vol) begin
      $error("volume_level: expected %0d, got %0d", e.vol, got.vol);
      fail_count++;
    end
    if (got.vol_chg !== e.vol_chg) begin
      $error("volume_changed: expected %0d, got %0d", e.vol_chg, got.vol_chg);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      check_status('{out_ch.tune_valid, out_ch.tune_freq_hz, out_ch.tune_mode,
                     out_ch.tune_bandwidth_hz, out_ch.scan_active, out_ch.scan_holding,
                     out_ch.preset_number, out_ch.volume_level, out_ch.volume_changed});
    end
  end

  // Result sink: stalls at random, rate set per phase
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst                = 1'b1;
    in_ch.valid        = 1'b0;
    in_ch.key_up       = 1'b0;
    in_ch.key_down     = 1'b0;
    in_ch.key_scan     = 1'b0;
    in_ch.key_mode     = 1'b0;
    in_ch.key_preset   = 1'b0;
    in_ch.key_vol_down = 1'b0;
    in_ch.key_vol_up   = 1'b0;
    in_ch.link_up      = 1'b0;
    in_ch.signal_level = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = '0;
    cfg_ch.data        = '0;
    fail_count         = 0;
    src_idle_pct       = 25;
    snk_idle_pct       = 25;

    // Predictor state after reset
    sq_lvl    = 300;
    dwell_lim = 180;
    pause_lim = 300;
    fine_sel  = 1'b0;
    hf_ceil   = 30000000;
    top_ceil  = 108000000;
    r_freq    = 10000000;
    r_mode    = MODE_AM;
    r_bw      = 6000;
    r_preset  = 1;
    r_scan    = 1'b0;
    r_dwell   = 0;
    r_hold    = 0;
    r_pend    = 1'b1;
    r_vol     = 255;
    r_prev    = '0;

    // Directed rows. Typed expectations only for the obvious ones.
    // Link down after reset: nothing moves, the initial tune waits.
    dir_tab[0]  = '{'{K_NONE, 1'b0, 10'd0}, 1'b1,
                    '{1'b0, 27'd10000000, MODE_AM, 14'd6000, 1'b0, 1'b0, 5'd1, 8'd255, 1'b0}};
    // Link comes up: the pending tune goes out.
    dir_tab[1]  = '{'{K_NONE, 1'b1, 10'd0}, 1'b1,
                    '{1'b1, 27'd10000000, MODE_AM, 14'd6000, 1'b0, 1'b0, 5'd1, 8'd255, 1'b0}};
    // Vol-up at full volume: stays at 255 but still flags a change.
    dir_tab[2]  = '{'{K_VUP, 1'b1, 10'd0}, 1'b1,
                    '{1'b0, 27'd10000000, MODE_AM, 14'd6000, 1'b0, 1'b0, 5'd1, 8'd255, 1'b1}};
    dir_tab[3]  = '{'{K_NONE, 1'b1, 10'd0}, 1'b0, '0};
    dir_tab[4]  = '{'{K_VDN, 1'b1, 10'd1023}, 1'b0, '0};
    dir_tab[5]  = '{'{K_UP, 1'b1, 10'd0}, 1'b0, '0};
    dir_tab[6]  = '{'{K_NONE, 1'b1, 10'd0}, 1'b0, '0};
    dir_tab[7]  = '{'{K_DOWN, 1'b1, 10'd0}, 1'b0, '0};
    dir_tab[8]  = '{'{K_MODE, 1'b1, 10'd0}, 1'b0, '0};
    dir_tab[9]  = '{'{K_NONE, 1'b1, 10'd0}, 1'b0, '0};
    dir_tab[10] = '{'{K_PRESET, 1'b1, 10'd0}, 1'b0, '0};
    dir_tab[11] = '{'{K_NONE, 1'b0, 10'd0}, 1'b0, '0};
    // Press with link down: edge is consumed, no action
    dir_tab[12] = '{'{K_UP, 1'b0, 10'd0}, 1'b0, '0};
    // Still held once the link is back: no new edge
    dir_tab[13] = '{'{K_UP, 1'b1, 10'd0}, 1'b0, '0};
    dir_tab[14] = '{'{K_NONE, 1'b1, 10'd0}, 1'b0, '0};
    // Up together with scan: the scan wins since it acts later
    dir_tab[15] = '{'{K_UP | K_SCAN, 1'b1, 10'd0}, 1'b0, '0};
    // Strong signal pauses, weak one resumes at once
    dir_tab[16] = '{'{K_NONE, 1'b1, 10'd1023}, 1'b0, '0};
    dir_tab[17] = '{'{K_NONE, 1'b1, 10'd0}, 1'b0, '0};
    // Just under, then exactly at, the squelch level
    dir_tab[18] = '{'{K_NONE, 1'b1, 10'd299}, 1'b0, '0};
    dir_tab[19] = '{'{K_NONE, 1'b1, 10'd300}, 1'b0, '0};
    dir_tab[20] = '{'{K_SCAN, 1'b1, 10'd0}, 1'b0, '0};
    // Every key at once
    dir_tab[21] = '{'{K_ALL, 1'b1, 10'd512}, 1'b0, '0};
    dir_tab[22] = '{'{K_NONE, 1'b0, 10'd1023}, 1'b0, '0};
    dir_tab[23] = '{'{K_MODE, 1'b1, 10'd0}, 1'b0, '0};
    dir_tab[24] = '{'{K_NONE, 1'b1, 10'd0}, 1'b0, '0};

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_N; i++) begin
      send_frame(dir_tab[i].f, dir_tab[i].typed, dir_tab[i].s);
    end

    // Short dwell and pause so the scanner walks presets
    retune_config(300, 3, 2, 0, 30000000, 108000000);
    play_random(62);

    // Squelch 0, dwell and pause 0, fine steps, HF ceiling 0 pins non-FM up
    retune_config(0, 0, 0, 1, 0, 108000000);
    write_reg(REG_SPARE, FREQ_MASK);
    cfg_ch.valid <= 1'b0;
    play_random(62);

    // Top ceiling 0: up clamps to 0, then down lands on exactly one step
    retune_config(1023, 65535, 65535, 0, 108000000, 0);
    play_random(62);

    // Dwell 1 with the longest pause, and no idling on either side
    src_idle_pct = 0;
    snk_idle_pct = 0;
    retune_config(512, 1, 65535, 1, 108000000, 108000000);
    play_random(62);

    src_idle_pct = 25;
    snk_idle_pct = 25;
    repeat (4) begin
      retune_config($urandom_range(1023), $urandom_range(1, 6), $urandom_range(0, 6),
                    $urandom_range(1), $urandom_range(108000000),
                    $urandom_range(108000000));
      play_random(62);
    end

    drain();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/rtsc_pkg.sv
rtl/rtsc_if.sv
rtl/receiver_tune_scan_controller_unit.sv
sim/tb_top.sv
